>>> rtl/acde_pkg.sv
package acde_pkg;

  localparam logic [1:0] CmdTick  = 2'd0;
  localparam logic [1:0] CmdPause = 2'd1;
  localparam logic [1:0] CmdAlarm = 2'd2;
  localparam logic [1:0] CmdKey   = 2'd3;

  localparam logic [1:0] ModeRun       = 2'd0;
  localparam logic [1:0] ModeEditTime  = 2'd1;
  localparam logic [1:0] ModeEditAlarm = 2'd2;

  localparam logic [3:0] Dash       = 4'd10;
  localparam int unsigned NumDigits = 6;
  localparam logic [2:0] LastPos    = 3'd5;

  localparam logic [4:0] MaxHour = 5'd23;
  localparam logic [5:0] MaxMin  = 6'd59;
  localparam logic [5:0] MaxSec  = 6'd59;
  localparam logic [6:0] MaxHourPair = 7'd23;
  localparam logic [6:0] MaxMinPair  = 7'd59;

  typedef logic [NumDigits-1:0][3:0] digits_t;

  // Complete clock state; it is also the result of the latest request.
  typedef struct packed {
    logic [4:0] time_hour;
    logic [5:0] time_minute;
    logic [5:0] time_second;
    logic [4:0] alarm_hour;
    logic [5:0] alarm_minute;
    logic [5:0] alarm_second;
    digits_t    digits;
    logic [2:0] entry_pos;
    logic [1:0] mode;
    logic       alarm_flag;
  } clk_state_t;

  // Tens digit of a value below 64, by comparison.
  function automatic logic [3:0] tens_of(logic [5:0] v);
    logic [3:0] t;
    if (v >= 6'd60)      t = 4'd6;
    else if (v >= 6'd50) t = 4'd5;
    else if (v >= 6'd40) t = 4'd4;
    else if (v >= 6'd30) t = 4'd3;
    else if (v >= 6'd20) t = 4'd2;
    else if (v >= 6'd10) t = 4'd1;
    else                 t = 4'd0;
    return t;
  endfunction

  function automatic logic [3:0] ones_of(logic [5:0] v);
    logic [3:0] t;
    logic [5:0] base;
    t    = tens_of(v);
    base = {t[2:0], 3'b000} + {2'b00, t[2:0], 1'b0};
    return 4'(v - base);
  endfunction

  function automatic digits_t show_digits(logic [4:0] h, logic [5:0] m, logic [5:0] s);
    digits_t d;
    d[0] = tens_of({1'b0, h});
    d[1] = ones_of({1'b0, h});
    d[2] = tens_of(m);
    d[3] = ones_of(m);
    d[4] = tens_of(s);
    d[5] = ones_of(s);
    return d;
  endfunction

  // Two entered digits (each up to a dash) as a number, clamped to a limit.
  function automatic logic [6:0] pair_clamped(logic [3:0] tens, logic [3:0] ones,
                                              logic [6:0] lim);
    logic [6:0] v;
    v = {tens, 3'b000} + {2'b00, tens, 1'b0} + {3'b000, ones};
    return (v > lim) ? lim : v;
  endfunction

endpackage

>>> rtl/acde_in_if.sv
interface acde_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [3:0] key_value;

  modport source (output valid, output cmd, output key_value, input ready);
  modport sink   (input valid, input cmd, input key_value, output ready);
endinterface

>>> rtl/acde_out_if.sv
interface acde_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] digit_h_tens;
  logic [3:0] digit_h_ones;
  logic [3:0] digit_m_tens;
  logic [3:0] digit_m_ones;
  logic [3:0] digit_s_tens;
  logic [3:0] digit_s_ones;
  logic       alarm_active;
  logic [1:0] clock_mode;
  logic [4:0] cur_hour;
  logic [5:0] cur_minute;
  logic [5:0] cur_second;

  modport source (output valid, output digit_h_tens, output digit_h_ones,
                  output digit_m_tens, output digit_m_ones, output digit_s_tens,
                  output digit_s_ones, output alarm_active, output clock_mode,
                  output cur_hour, output cur_minute, output cur_second,
                  input ready);
  modport sink   (input valid, input digit_h_tens, input digit_h_ones,
                  input digit_m_tens, input digit_m_ones, input digit_s_tens,
                  input digit_s_ones, input alarm_active, input clock_mode,
                  input cur_hour, input cur_minute, input cur_second,
                  output ready);
endinterface

>>> rtl/acde_step.sv
module acde_step (
  input  acde_pkg::clk_state_t cur_i,
  input  logic [1:0]           cmd_i,
  input  logic [3:0]           key_value_i,
  output acde_pkg::clk_state_t nxt_o
);

  acde_pkg::clk_state_t nxt;
  acde_pkg::digits_t    dig;
  logic [3:0] k;
  logic [2:0] pos;
  logic [4:0] hour_inc;
  logic [5:0] min_inc;
  logic [5:0] sec_inc;
  logic [6:0] new_h;
  logic [6:0] new_m;
  logic [6:0] new_s;
  logic       editing;

  always_comb begin
    nxt = cur_i;
    dig = cur_i.digits;
    k   = (key_value_i > acde_pkg::Dash) ? acde_pkg::Dash : key_value_i;
    pos = (cur_i.entry_pos > acde_pkg::LastPos) ? acde_pkg::LastPos : cur_i.entry_pos;
    editing = (cur_i.mode == acde_pkg::ModeEditTime) || (cur_i.mode == acde_pkg::ModeEditAlarm);

    // Carry chain for the one-second advance.
    sec_inc  = (cur_i.time_second == acde_pkg::MaxSec) ? 6'd0 : cur_i.time_second + 6'd1;
    min_inc  = cur_i.time_minute;
    hour_inc = cur_i.time_hour;
    if (cur_i.time_second == acde_pkg::MaxSec) begin
      min_inc = (cur_i.time_minute == acde_pkg::MaxMin) ? 6'd0 : cur_i.time_minute + 6'd1;
      if (cur_i.time_minute == acde_pkg::MaxMin) begin
        hour_inc = (cur_i.time_hour == acde_pkg::MaxHour) ? 5'd0 : cur_i.time_hour + 5'd1;
      end
    end

    new_h = 7'd0;
    new_m = 7'd0;
    new_s = 7'd0;

    unique case (cmd_i)
      acde_pkg::CmdTick: begin
        if (cur_i.mode != acde_pkg::ModeEditTime) begin
          nxt.time_hour   = hour_inc;
          nxt.time_minute = min_inc;
          nxt.time_second = sec_inc;
          if (cur_i.mode != acde_pkg::ModeEditAlarm) begin
            nxt.digits = acde_pkg::show_digits(hour_inc, min_inc, sec_inc);
          end
          if (hour_inc == cur_i.alarm_hour && min_inc == cur_i.alarm_minute &&
              sec_inc == cur_i.alarm_second) begin
            nxt.alarm_flag = 1'b1;
          end
        end
      end
      acde_pkg::CmdPause: begin
        if (cur_i.mode != acde_pkg::ModeEditTime) begin
          nxt.mode      = acde_pkg::ModeEditTime;
          nxt.entry_pos = 3'd0;
          nxt.digits    = {acde_pkg::NumDigits{acde_pkg::Dash}};
        end else begin
          nxt.mode   = acde_pkg::ModeRun;
          nxt.digits = acde_pkg::show_digits(cur_i.time_hour, cur_i.time_minute,
                                             cur_i.time_second);
        end
      end
      acde_pkg::CmdAlarm: begin
        if (cur_i.mode != acde_pkg::ModeEditAlarm) begin
          nxt.entry_pos = 3'd0;
          nxt.digits    = acde_pkg::show_digits(cur_i.alarm_hour, cur_i.alarm_minute,
                                                cur_i.alarm_second);
          // On a raised alarm, the button silences it and goes to run mode.
          if (cur_i.alarm_flag) begin
            nxt.alarm_flag = 1'b0;
            nxt.mode       = acde_pkg::ModeRun;
          end else begin
            nxt.mode = acde_pkg::ModeEditAlarm;
          end
        end else begin
          nxt.mode   = acde_pkg::ModeRun;
          nxt.digits = acde_pkg::show_digits(cur_i.time_hour, cur_i.time_minute,
                                             cur_i.time_second);
        end
      end
      acde_pkg::CmdKey: begin
        if (editing) begin
          dig[pos] = k;
          if (pos == 3'd0 && cur_i.mode == acde_pkg::ModeEditAlarm) begin
            dig[1] = acde_pkg::Dash;
            dig[2] = acde_pkg::Dash;
            dig[3] = acde_pkg::Dash;
            dig[4] = acde_pkg::Dash;
            dig[5] = acde_pkg::Dash;
          end
          new_h = acde_pkg::pair_clamped(dig[0], dig[1], acde_pkg::MaxHourPair);
          new_m = acde_pkg::pair_clamped(dig[2], dig[3], acde_pkg::MaxMinPair);
          new_s = acde_pkg::pair_clamped(dig[4], dig[5], acde_pkg::MaxMinPair);
          if (pos == 3'd0 && cur_i.mode == acde_pkg::ModeEditAlarm && k == acde_pkg::Dash) begin
            nxt.entry_pos = 3'd0;
          end else if (k == acde_pkg::Dash && pos != 3'd0) begin
            // Backspace: step back and blank the previous digit too.
            dig[pos - 3'd1] = acde_pkg::Dash;
            nxt.entry_pos   = pos - 3'd1;
          end else if (pos == acde_pkg::LastPos) begin
            if (cur_i.mode == acde_pkg::ModeEditTime) begin
              nxt.time_hour   = new_h[4:0];
              nxt.time_minute = new_m[5:0];
              nxt.time_second = new_s[5:0];
            end else begin
              nxt.alarm_hour   = new_h[4:0];
              nxt.alarm_minute = new_m[5:0];
              nxt.alarm_second = new_s[5:0];
            end
            nxt.mode      = acde_pkg::ModeRun;
            nxt.entry_pos = acde_pkg::LastPos;
          end else begin
            nxt.entry_pos = pos + 3'd1;
          end
          nxt.digits = dig;
        end
      end
      default: begin
        nxt = cur_i;
      end
    endcase
  end

  assign nxt_o = nxt;

endmodule

>>> rtl/alarm_clock_with_digit_entry.sv
// A 24-hour hh:mm:ss alarm clock driven by requests: a one-second tick, the
// pause/edit button, the alarm-set button and a decoded key (0-9, or 10 for
// dash/backspace). Every request yields exactly one result that holds the
// whole visible state after it: six display digits, the alarm line, the mode
// and the current time. Requests are registered on entry, and the clock state
// register that the next-state logic writes is also the result register, so
// a request passes the entry register, then the state register; one request
// per cycle is sustained as long as results are taken; a stalled result holds
// the state, and one further request waits in the entry register.
module alarm_clock_with_digit_entry (
  input  logic              clk_i,
  input  logic              rst_ni,
  acde_in_if.sink           in_i,
  acde_out_if.source        out_o
);

  logic                 in_valid_q;
  logic [1:0]           cmd_q;
  logic [3:0]           key_q;
  logic                 out_valid_q;
  logic                 advance;
  acde_pkg::clk_state_t state_q;
  acde_pkg::clk_state_t state_d;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      cmd_q <= in_i.cmd;
      key_q <= in_i.key_value;
    end
  end

  acde_step u_step (
    .cur_i       (state_q),
    .cmd_i       (cmd_q),
    .key_value_i (key_q),
    .nxt_o       (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      state_q     <= state_d;
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.digit_h_tens = state_q.digits[0];
  assign out_o.digit_h_ones = state_q.digits[1];
  assign out_o.digit_m_tens = state_q.digits[2];
  assign out_o.digit_m_ones = state_q.digits[3];
  assign out_o.digit_s_tens = state_q.digits[4];
  assign out_o.digit_s_ones = state_q.digits[5];
  assign out_o.alarm_active = state_q.alarm_flag;
  assign out_o.clock_mode   = state_q.mode;
  assign out_o.cur_hour     = state_q.time_hour;
  assign out_o.cur_minute   = state_q.time_minute;
  assign out_o.cur_second   = state_q.time_second;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.entry_pos <= acde_pkg::LastPos)
    else $error("entry position beyond the last digit");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.time_hour <= acde_pkg::MaxHour && state_q.time_minute <= acde_pkg::MaxMin &&
    state_q.time_second <= acde_pkg::MaxSec)
    else $error("time out of range");

  a_alarm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.alarm_hour <= acde_pkg::MaxHour && state_q.alarm_minute <= acde_pkg::MaxMin &&
    state_q.alarm_second <= acde_pkg::MaxSec)
    else $error("alarm time out of range");

  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> $stable(state_q))
    else $error("state changed under a stalled result");

  a_entry_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |-> !in_i.ready)
    else $error("request accepted over a waiting one");

endmodule

>>> tb/tb_alarm_clock_with_digit_entry.sv
module tb_alarm_clock_with_digit_entry;

  localparam int CycleLimit  = 200000;
  localparam int HoldCycles  = 80;
  localparam int PhaseItems  = 500;
  localparam int SecondsDay  = 86400;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] key;
  } clock_req_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [4:0] al_hour;
    logic [5:0] al_minute;
    logic [5:0] al_second;
    acde_pkg::digits_t shown;
    logic [2:0] pos;
    logic [1:0] mode;
    logic       alarm;
  } clock_state_t;

  typedef struct packed {
    acde_pkg::digits_t shown;
    logic       alarm;
    logic [1:0] mode;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } clock_view_t;

  logic clk_i;
  logic rst_ni;

  acde_in_if  req_if ();
  acde_out_if res_if ();

  alarm_clock_with_digit_entry u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  clock_req_t   pending_events[$];
  clock_view_t  predicted_views[$];
  clock_state_t model_clock = '0;
  clock_state_t plan_clock  = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_rx = 1'b0;
  event        hold_trig;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          phase_items = 0;

  always #5 clk_i = ~clk_i;

  function automatic acde_pkg::digits_t time_digits(logic [4:0] h, logic [5:0] m,
                                                    logic [5:0] s);
    acde_pkg::digits_t d;
    d[0] = 4'(h / 5'd10);
    d[1] = 4'(h % 5'd10);
    d[2] = 4'(m / 6'd10);
    d[3] = 4'(m % 6'd10);
    d[4] = 4'(s / 6'd10);
    d[5] = 4'(s % 6'd10);
    return d;
  endfunction

  function automatic acde_pkg::digits_t secs_digits(int t);
    return time_digits(5'(t / 3600), 6'((t / 60) % 60), 6'(t % 60));
  endfunction

  // A dash reads as ten here, so a dashed tens digit always clamps.
  function automatic int clamp_pair(logic [3:0] tens, logic [3:0] ones, int lim);
    int v;
    v = int'(tens) * 10 + int'(ones);
    return (v > lim) ? lim : v;
  endfunction

  function automatic clock_state_t next_clock(clock_state_t s, clock_req_t r);
    clock_state_t n;
    logic [3:0]   k;
    logic [2:0]   p;
    logic         stay;
    int           hh, mm, ss;
    n = s;
    case (r.cmd)
      acde_pkg::CmdTick: begin
        if (s.mode != acde_pkg::ModeEditTime) begin
          ss = (int'(s.second) + 1) % 60;
          mm = int'(s.minute);
          hh = int'(s.hour);
          if (ss == 0) begin
            mm = (mm + 1) % 60;
            if (mm == 0) hh = (hh + 1) % 24;
          end
          n.hour   = 5'(hh);
          n.minute = 6'(mm);
          n.second = 6'(ss);
          if (s.mode != acde_pkg::ModeEditAlarm)
            n.shown = time_digits(n.hour, n.minute, n.second);
          if (n.hour == n.al_hour && n.minute == n.al_minute && n.second == n.al_second)
            n.alarm = 1'b1;
        end
      end
      acde_pkg::CmdPause: begin
        if (s.mode != acde_pkg::ModeEditTime) begin
          n.mode  = acde_pkg::ModeEditTime;
          n.pos   = '0;
          n.shown = {acde_pkg::NumDigits{acde_pkg::Dash}};
        end else begin
          n.mode  = acde_pkg::ModeRun;
          n.shown = time_digits(s.hour, s.minute, s.second);
        end
      end
      acde_pkg::CmdAlarm: begin
        if (s.mode != acde_pkg::ModeEditAlarm) begin
          n.mode  = acde_pkg::ModeEditAlarm;
          n.pos   = '0;
          n.shown = time_digits(s.al_hour, s.al_minute, s.al_second);
          // Pressing the button on a raised alarm dismisses it and goes to run mode; the alarm time is shown.
          if (s.alarm) begin
            n.alarm = 1'b0;
            n.mode  = acde_pkg::ModeRun;
          end
        end else begin
          n.mode  = acde_pkg::ModeRun;
          n.shown = time_digits(s.hour, s.minute, s.second);
        end
      end
      acde_pkg::CmdKey: begin
        if (s.mode == acde_pkg::ModeEditTime || s.mode == acde_pkg::ModeEditAlarm) begin
          k    = (r.key > acde_pkg::Dash) ? acde_pkg::Dash : r.key;
          p    = (s.pos > acde_pkg::LastPos) ? acde_pkg::LastPos : s.pos;
          stay = 1'b0;
          n.shown[p] = k;
          if (p == 3'd0 && s.mode == acde_pkg::ModeEditAlarm) begin
            for (int i = 1; i < acde_pkg::NumDigits; i++) n.shown[i] = acde_pkg::Dash;
            stay = (k == acde_pkg::Dash);
          end
          if (stay) begin
            n.pos = '0;
          end else if (k == acde_pkg::Dash && p != 3'd0) begin
            n.shown[p - 3'd1] = acde_pkg::Dash;
            n.pos = p - 3'd1;
          end else if (p == acde_pkg::LastPos) begin
            hh = clamp_pair(n.shown[0], n.shown[1], int'(acde_pkg::MaxHour));
            mm = clamp_pair(n.shown[2], n.shown[3], int'(acde_pkg::MaxMin));
            ss = clamp_pair(n.shown[4], n.shown[5], int'(acde_pkg::MaxSec));
            if (s.mode == acde_pkg::ModeEditTime) begin
              n.hour   = 5'(hh);
              n.minute = 6'(mm);
              n.second = 6'(ss);
            end else begin
              n.al_hour   = 5'(hh);
              n.al_minute = 6'(mm);
              n.al_second = 6'(ss);
            end
            n.mode = acde_pkg::ModeRun;
            n.pos  = acde_pkg::LastPos;
          end else begin
            n.pos = p + 3'd1;
          end
        end
      end
    endcase
    return n;
  endfunction

  task automatic push_req(logic [1:0] c, logic [3:0] k);
    clock_req_t r;
    r.cmd = c;
    r.key = k;
    plan_clock = next_clock(plan_clock, r);
    pending_events.push_back(r);
    phase_items++;
  endtask

  // Leaves any editing mode, opens the wanted one and types six digits,
  // sometimes with a backspace and a retyped digit on the way.
  task automatic enter_setting(logic to_alarm, acde_pkg::digits_t dg);
    int fix_at;
    while (plan_clock.mode != acde_pkg::ModeRun)
      push_req((plan_clock.mode == acde_pkg::ModeEditTime) ? acde_pkg::CmdPause
                                                           : acde_pkg::CmdAlarm,
               4'($urandom_range(15)));
    if (to_alarm) begin
      while (plan_clock.mode != acde_pkg::ModeEditAlarm)
        push_req(acde_pkg::CmdAlarm, 4'($urandom_range(15)));
    end else begin
      push_req(acde_pkg::CmdPause, 4'($urandom_range(15)));
    end
    fix_at = ($urandom_range(3) == 0) ? int'($urandom_range(1, 5)) : -1;
    for (int i = 0; i < acde_pkg::NumDigits; i++) begin
      if (i == fix_at) begin
        push_req(acde_pkg::CmdKey, 4'(acde_pkg::Dash + $urandom_range(5)));
        push_req(acde_pkg::CmdKey, dg[i - 1]);
      end
      push_req(acde_pkg::CmdKey, dg[i]);
    end
  endtask

  task automatic wait_quiet();
    do @(negedge clk_i);
    while (pending_events.size() != 0 || req_if.valid || predicted_views.size() != 0);
  endtask

  task automatic report_mismatch(string msg);
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
  endtask

  // Request driver; the accepted request also advances the predicted clock.
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    clock_req_t r;
    if (!rst_ni) begin
      req_if.valid     <= 1'b0;
      req_if.cmd       <= acde_pkg::CmdTick;
      req_if.key_value <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        r.cmd = req_if.cmd;
        r.key = req_if.key_value;
        model_clock = next_clock(model_clock, r);
        predicted_views.push_back({model_clock.shown, model_clock.alarm, model_clock.mode,
                                   model_clock.hour, model_clock.minute, model_clock.second});
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          r = pending_events.pop_front();
          req_if.valid     <= 1'b1;
          req_if.cmd       <= r.cmd;
          req_if.key_value <= r.key;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always begin : rx_hold
    @(hold_trig);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  always @(posedge clk_i) begin : check_results
    clock_view_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (predicted_views.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
      end else begin
        want = predicted_views.pop_front();
        check_field("digit_h_tens", int'(res_if.digit_h_tens), int'(want.shown[0]));
        check_field("digit_h_ones", int'(res_if.digit_h_ones), int'(want.shown[1]));
        check_field("digit_m_tens", int'(res_if.digit_m_tens), int'(want.shown[2]));
        check_field("digit_m_ones", int'(res_if.digit_m_ones), int'(want.shown[3]));
        check_field("digit_s_tens", int'(res_if.digit_s_tens), int'(want.shown[4]));
        check_field("digit_s_ones", int'(res_if.digit_s_ones), int'(want.shown[5]));
        check_field("alarm_active", int'(res_if.alarm_active), int'(want.alarm));
        check_field("clock_mode", int'(res_if.clock_mode), int'(want.mode));
        check_field("cur_hour", int'(res_if.cur_hour), int'(want.hour));
        check_field("cur_minute", int'(res_if.cur_minute), int'(want.minute));
        check_field("cur_second", int'(res_if.cur_second), int'(want.second));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int t;
    int d;
    clk_i  = 1'b0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 7;  recv_idle_pct = 53; end
        1: begin send_idle_pct = 53; recv_idle_pct = 7;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      phase_items = 0;
      if (ph == 0) begin
        push_req(acde_pkg::CmdKey, 4'd7);
        push_req(acde_pkg::CmdPause, 4'd0);
        push_req(acde_pkg::CmdTick, 4'd15);
        push_req(acde_pkg::CmdKey, 4'd2);
        push_req(acde_pkg::CmdKey, 4'd3);
        push_req(acde_pkg::CmdKey, 4'd5);
        push_req(acde_pkg::CmdKey, 4'd9);
        push_req(acde_pkg::CmdKey, 4'd5);
        // An out-of-range key at the last position acts as backspace.
        push_req(acde_pkg::CmdKey, 4'd15);
        push_req(acde_pkg::CmdKey, 4'd5);
        push_req(acde_pkg::CmdKey, 4'd8);
        push_req(acde_pkg::CmdTick, 4'd0);
        push_req(acde_pkg::CmdAlarm, 4'd0);
        push_req(acde_pkg::CmdAlarm, 4'd0);
        push_req(acde_pkg::CmdTick, 4'd0);
        push_req(acde_pkg::CmdKey, acde_pkg::Dash);
        push_req(acde_pkg::CmdPause, 4'd0);
        push_req(acde_pkg::CmdAlarm, 4'd0);
        push_req(acde_pkg::CmdPause, 4'd0);
        // A dash as the first time digit makes the hour clamp to its maximum.
        push_req(acde_pkg::CmdKey, acde_pkg::Dash);
        repeat (5) push_req(acde_pkg::CmdKey, 4'd9);
        wait_quiet();
      end
      while (phase_items < PhaseItems) begin
        case ($urandom_range(9))
          0, 1, 2: repeat ($urandom_range(1, 8))
            push_req(acde_pkg::CmdTick, 4'($urandom_range(15)));
          3, 4: begin
            if ($urandom_range(3) == 0) begin
              for (int i = 0; i < acde_pkg::NumDigits; i++) d[i] = 1'b0;
              enter_setting(1'b0, acde_pkg::digits_t'({$urandom, $urandom}));
            end else begin
              t = ($urandom_range(3) == 0) ? SecondsDay - int'($urandom_range(1, 70))
                                            : int'($urandom_range(SecondsDay - 1));
              enter_setting(1'b0, secs_digits(t));
            end
          end
          5, 6: begin
            t = ($urandom_range(2) == 0) ? SecondsDay - int'($urandom_range(1, 8))
                                          : int'($urandom_range(SecondsDay - 1));
            d = $urandom_range(1, 5);
            enter_setting(1'b0, secs_digits(t));
            enter_setting(1'b1, secs_digits((t + d) % SecondsDay));
            repeat (d + int'($urandom_range(2)))
              push_req(acde_pkg::CmdTick, 4'($urandom_range(15)));
            if ($urandom_range(1) == 1) push_req(acde_pkg::CmdAlarm, 4'($urandom_range(15)));
          end
          7: enter_setting(1'b1, secs_digits(int'($urandom_range(SecondsDay - 1))));
          default: begin
            repeat ($urandom_range(1, 6))
              push_req(2'($urandom_range(3)), 4'($urandom_range(15)));
          end
        endcase
      end
      if (ph == 2) begin
        // Stall the results while requests keep coming so the block backs up.
        while (pending_events.size() > PhaseItems / 2) @(negedge clk_i);
        -> hold_trig;
      end
      wait_quiet();
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
